// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/wzp_pkg.sv =====
package wzp_pkg;

	// defaults for the top-level parameters
	localparam int DEF_MAX_WINDOW = 1024;
	localparam int DEF_COUNT_BITS = 16;

	// register widths
	localparam int WS_W  = 11;
	localparam int CL_W  = 16;
	localparam int WL_W  = 26;
	localparam int K_W   = 4;
	localparam int K2_W  = 2 * K_W;
	localparam int ADDR_W = 4;

	// register reset values
	localparam logic [WS_W-1:0] RST_WINDOW_SIZE = 11'd200;
	localparam logic [CL_W-1:0] RST_COUNT_LIMIT = 16'd5;
	localparam logic [WL_W-1:0] RST_WINDOW_LIMIT = 26'd10;
	localparam logic [K_W-1:0]  RST_DEV_FACTOR = 4'd3;

	typedef enum logic [1:0] {
		REG_WINDOW_SIZE  = 2'd0,
		REG_COUNT_LIMIT  = 2'd1,
		REG_WINDOW_LIMIT = 2'd2,
		REG_DEV_FACTOR   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK            = 2'd0,
		ST_PAUSE_LOW     = 2'd1,
		ST_PAUSE_CHANGED = 2'd2,
		ST_TOO_MANY      = 2'd3
	} status_t;

	// products formed by the shared multiplier, in issue order
	typedef enum logic [2:0] {
		OP_PW  = 3'd0,
		OP_QW  = 3'd1,
		OP_SS  = 3'd2,
		OP_RHS = 3'd3,
		OP_LL  = 3'd4,
		OP_LHS = 3'd5
	} mul_op_t;

	typedef struct packed {
		logic [WS_W-1:0] window_size;
		logic [CL_W-1:0] count_limit;
		logic [WL_W-1:0] window_limit;
		logic [K_W-1:0]  dev_factor;
	} cfg_t;

	typedef struct packed {
		logic    start;
		mul_op_t op;
		logic    finish;
	} cmd_t;

	typedef struct packed {
		logic end_fire;
		logic mul_done;
		logic out_free;
	} sts_t;

	function automatic int f_max(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	function automatic mul_op_t f_next_op(input mul_op_t op);
		mul_op_t r;
		case (op)
			OP_PW:   r = OP_QW;
			OP_QW:   r = OP_SS;
			OP_SS:   r = OP_RHS;
			OP_RHS:  r = OP_LL;
			OP_LL:   r = OP_LHS;
			default: r = OP_PW;
		endcase
		return r;
	endfunction

	// datapath widths
	function automatic int f_sum_w(input int cb, input int mw);
		return cb + $clog2(mw);
	endfunction

	function automatic int f_l_w(input int cb);
		return cb + WS_W;
	endfunction

	function automatic int f_d_w(input int cb, input int mw);
		return f_max(2 * cb + $clog2(mw) + WS_W, 2 * f_sum_w(cb, mw));
	endfunction

	function automatic int f_pr_w(input int cb, input int mw);
		return f_max(2 * f_l_w(cb) + WS_W, f_d_w(cb, mw) + K2_W + WS_W);
	endfunction

	function automatic int f_mb_w(input int cb, input int mw);
		return f_max(f_max(f_sum_w(cb, mw), f_l_w(cb)), K2_W + WS_W);
	endfunction

endpackage

// ===== rtl/core/window_zscore_pause_test.sv =====
// A result item appears after the six products for its window-end item finish.
// MB, the serial multiplier width, is 27 with default parameters.
// One non-end item is taken per cycle; a window-end item stalls the input for the
// whole test, and longer while a result item waits.
// Reset (arst_n low, async): statistics, error, handshakes clear; registers
// return to 200/5/10/3. No memory, so no clearing pass.
//
// Each non-skip item that fits in the window adds its count to the window sum and
// queues count^2 for the square sum (pipelined); any item may set the first error.
// On the end item the controller runs six products in turn through one
// shift-add multiplier:
//   P*W, Q*W, S*S, D*(k^2*W), L*L, L^2*(W-1)
// with L = P*W - S and D = Q*W - S^2 clipped at zero. The candidate is a
// pause when no error is held, S >= P + window_limit, L > 0 and
// L^2*(W-1) > k^2*W*D. The result item then waits in the output register;
// the statistics clear and the next window may start while it waits.
// Config writes go through an APB-style port, one word per register.
module window_zscore_pause_test #(
	parameter int MAX_WINDOW = wzp_pkg::DEF_MAX_WINDOW,
	parameter int COUNT_BITS = wzp_pkg::DEF_COUNT_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// config port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wzp_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// input items
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [COUNT_BITS-1:0]       count,
	input  logic [COUNT_BITS-1:0]       pause_value,
	input  logic                        skip,
	input  logic                        window_end,
	// result items
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        is_pause,
	output logic [wzp_pkg::f_sum_w(COUNT_BITS, MAX_WINDOW)-1:0] total_count,
	output logic [1:0]                  status
);

	import wzp_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic in_fire;
	logic cfg_wr;

	// register i at byte address 4*i
	reg_idx_t reg_idx;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_size  <= RST_WINDOW_SIZE;
			cfg_q.count_limit  <= RST_COUNT_LIMIT;
			cfg_q.window_limit <= RST_WINDOW_LIMIT;
			cfg_q.dev_factor   <= RST_DEV_FACTOR;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_WINDOW_SIZE:  cfg_q.window_size  <= pwdata[WS_W-1:0];
				REG_COUNT_LIMIT:  cfg_q.count_limit  <= pwdata[CL_W-1:0];
				REG_WINDOW_LIMIT: cfg_q.window_limit <= pwdata[WL_W-1:0];
				REG_DEV_FACTOR:   cfg_q.dev_factor   <= pwdata[K_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WINDOW_SIZE:  prdata = 32'(cfg_q.window_size);
			REG_COUNT_LIMIT:  prdata = 32'(cfg_q.count_limit);
			REG_WINDOW_LIMIT: prdata = 32'(cfg_q.window_limit);
			REG_DEV_FACTOR:   prdata = 32'(cfg_q.dev_factor);
			default:          prdata = '0;
		endcase
	end

	assign in_fire = in_valid && in_ready;

	wzp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.sts     (sts),
		.cmd     (cmd),
		.in_ready(in_ready)
	);

	wzp_dp #(
		.MAX_WINDOW(MAX_WINDOW),
		.COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd        (cmd),
		.sts        (sts),
		.in_fire    (in_fire),
		.count      (count),
		.pause_value(pause_value),
		.skip       (skip),
		.window_end (window_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.is_pause   (is_pause),
		.total_count(total_count),
		.status     (status)
	);

endmodule

// ===== rtl/core/wzp_mul.sv =====
`include "assert_macros.svh"

module wzp_mul #(
	parameter int A_W = 72,
	parameter int B_W = 27
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [A_W-1:0] a,
	input  logic [B_W-1:0] b,
	output logic           busy,
	output logic           done,
	output logic [A_W-1:0] product
);

	localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

	logic [A_W-1:0]   acc_q;
	logic [A_W-1:0]   a_q;
	logic [B_W-1:0]   b_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	// one multiplier bit per cycle, LSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[A_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[B_W-1:1]};
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign product = acc_q;

	`ASSERT_IMPLIES(a_start_idle, clk, arst_n, start, !busy_q)

endmodule

// ===== rtl/core/wzp_dp.sv =====
`include "assert_macros.svh"

module wzp_dp #(
	parameter int MAX_WINDOW = 1024,
	parameter int COUNT_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  wzp_pkg::cfg_t            cfg,
	input  wzp_pkg::cmd_t            cmd,
	output wzp_pkg::sts_t            sts,
	input  logic                     in_fire,
	input  logic [COUNT_BITS-1:0]    count,
	input  logic [COUNT_BITS-1:0]    pause_value,
	input  logic                     skip,
	input  logic                     window_end,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     is_pause,
	output logic [wzp_pkg::f_sum_w(COUNT_BITS, MAX_WINDOW)-1:0] total_count,
	output logic [1:0]               status
);

	import wzp_pkg::*;

	localparam int P_W   = COUNT_BITS;
	localparam int SUM_W = f_sum_w(COUNT_BITS, MAX_WINDOW);
	localparam int SQ_W  = 2 * COUNT_BITS + $clog2(MAX_WINDOW);
	localparam int L_W   = f_l_w(COUNT_BITS);
	localparam int D_W   = f_d_w(COUNT_BITS, MAX_WINDOW);
	localparam int KW_W  = K2_W + WS_W;
	localparam int PR_W  = f_pr_w(COUNT_BITS, MAX_WINDOW);
	localparam int MB_W  = f_mb_w(COUNT_BITS, MAX_WINDOW);
	localparam int LIM_W = f_max(SUM_W, WL_W) + 1;

	// effective window size
	logic [WS_W-1:0] w;
	always_comb begin
		if (cfg.window_size < WS_W'(2)) begin
			w = WS_W'(2);
		end else if (32'(cfg.window_size) > MAX_WINDOW) begin
			w = WS_W'(MAX_WINDOW);
		end else begin
			w = cfg.window_size;
		end
	end

	// window statistics
	logic [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]   sq_q;
	logic [WS_W-1:0]   items_q;
	logic [P_W-1:0]    held_q;
	status_t           err_q;
	logic [2*P_W-1:0]  sqr_s1;
	logic              add_s1;

	status_t err_n;
	logic    counted;
	logic    full;

	always_comb begin
		full    = (items_q >= w);
		counted = in_fire && !skip;
		err_n   = err_q;
		if (err_n == ST_OK && pause_value < cfg.count_limit) begin
			err_n = ST_PAUSE_LOW;
		end
		if (!skip) begin
			if (err_n == ST_OK && items_q != '0 && pause_value != held_q) begin
				err_n = ST_PAUSE_CHANGED;
			end
			if (err_n == ST_OK && full) begin
				err_n = ST_TOO_MANY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			sq_q    <= '0;
			items_q <= '0;
			held_q  <= '0;
			err_q   <= ST_OK;
			add_s1  <= 1'b0;
		end else begin
			add_s1 <= counted && !full;
			if (cmd.finish) begin
				sum_q   <= '0;
				sq_q    <= '0;
				items_q <= '0;
				held_q  <= '0;
				err_q   <= ST_OK;
			end else begin
				if (in_fire) begin
					err_q <= err_n;
				end
				if (counted) begin
					held_q <= pause_value;
					if (!full) begin
						sum_q   <= sum_q + SUM_W'(count);
						items_q <= items_q + 1'b1;
					end
				end
				// square is registered and lands in the cycle after its item
				if (add_s1) begin
					sq_q <= sq_q + SQ_W'(sqr_s1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		sqr_s1 <= count * count;
	end

	// k^2 * W, from registers only
	logic [K2_W-1:0] k2_q;
	logic [KW_W-1:0] kw_q;
	always_ff @(posedge clk) begin
		k2_q <= cfg.dev_factor * cfg.dev_factor;
		kw_q <= k2_q * w;
	end

	// shared multiplier and its operands
	logic [PR_W-1:0] mul_a;
	logic [MB_W-1:0] mul_b;
	logic [PR_W-1:0] product;
	logic            mul_busy;
	logic            mul_done;

	logic [L_W-1:0]   l_q;
	logic             lpos_q;
	logic [D_W-1:0]   qw_q;
	logic [D_W-1:0]   d_q;
	logic [PR_W-1:0]  rhs_q;
	logic [2*L_W-1:0] ll_q;
	logic             gt_q;

	always_comb begin
		case (cmd.op)
			OP_PW: begin
				mul_a = PR_W'(held_q);
				mul_b = MB_W'(w);
			end
			OP_QW: begin
				mul_a = PR_W'(sq_q);
				mul_b = MB_W'(w);
			end
			OP_SS: begin
				mul_a = PR_W'(sum_q);
				mul_b = MB_W'(sum_q);
			end
			OP_RHS: begin
				mul_a = PR_W'(d_q);
				mul_b = MB_W'(kw_q);
			end
			OP_LL: begin
				mul_a = PR_W'(l_q);
				mul_b = MB_W'(l_q);
			end
			OP_LHS: begin
				mul_a = PR_W'(ll_q);
				mul_b = MB_W'(w - 1'b1);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	wzp_mul #(
		.A_W(PR_W),
		.B_W(MB_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.done   (mul_done),
		.product(product)
	);

	// capture each product as it finishes
	always_ff @(posedge clk) begin
		if (mul_done) begin
			case (cmd.op)
				OP_PW: begin
					if (product > PR_W'(sum_q)) begin
						l_q    <= L_W'(product - PR_W'(sum_q));
						lpos_q <= 1'b1;
					end else begin
						l_q    <= '0;
						lpos_q <= 1'b0;
					end
				end
				OP_QW: qw_q <= D_W'(product);
				OP_SS: begin
					if (product > PR_W'(qw_q)) begin
						d_q <= '0;
					end else begin
						d_q <= qw_q - D_W'(product);
					end
				end
				OP_RHS: rhs_q <= product;
				OP_LL:  ll_q <= (2*L_W)'(product);
				OP_LHS: gt_q <= (product > rhs_q);
				default: ;
			endcase
		end
	end

	// result register
	logic [LIM_W-1:0] lim;
	logic             pre_ok;
	logic             out_valid_q;
	logic             is_pause_q;
	logic [SUM_W-1:0] total_q;
	logic [1:0]       status_q;

	always_comb begin
		lim    = LIM_W'(held_q) + LIM_W'(cfg.window_limit);
		pre_ok = (err_q == ST_OK) && (LIM_W'(sum_q) >= lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			is_pause_q <= pre_ok && lpos_q && gt_q;
			total_q    <= sum_q;
			status_q   <= err_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign is_pause     = is_pause_q;
	assign total_count  = total_q;
	assign status       = status_q;
	assign sts.end_fire = in_fire && window_end;
	assign sts.mul_done = mul_done;
	assign sts.out_free = !out_valid_q || out_ready;

	`ASSERT_IMPLIES(a_no_item_in_test, clk, arst_n, in_fire, !mul_busy)
	`ASSERT_IMPLIES(a_finish_slot_free, clk, arst_n, cmd.finish, !out_valid_q || out_ready)

endmodule

// ===== rtl/core/wzp_ctrl.sv =====
`include "assert_macros.svh"

module wzp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  wzp_pkg::sts_t sts,
	output wzp_pkg::cmd_t cmd,
	output logic          in_ready
);

	import wzp_pkg::*;

	typedef enum logic [3:0] {
		S_ACC  = 4'b0001,
		S_LOAD = 4'b0010,
		S_BUSY = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t  state_q;
	mul_op_t op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC;
			op_q    <= OP_PW;
		end else begin
			case (state_q)
				S_ACC: begin
					if (sts.end_fire) begin
						op_q    <= OP_PW;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: state_q <= S_BUSY;
				S_BUSY: begin
					if (sts.mul_done) begin
						if (op_q == OP_LHS) begin
							state_q <= S_FIN;
						end else begin
							op_q    <= f_next_op(op_q);
							state_q <= S_LOAD;
						end
					end
				end
				S_FIN: begin
					if (sts.out_free) begin
						state_q <= S_ACC;
					end
				end
				default: state_q <= S_ACC;
			endcase
		end
	end

	assign in_ready   = (state_q == S_ACC);
	assign cmd.start  = (state_q == S_LOAD);
	assign cmd.op     = op_q;
	assign cmd.finish = (state_q == S_FIN) && sts.out_free;

	`ASSERT_NEXT(a_end_stalls_input, clk, arst_n, sts.end_fire, !in_ready)

endmodule
